@@ rtl/acfp_pkg.sv @@
// ----------------------------------------------------------------------------
// acfp_pkg
// Shared types, character codes and the hex digit decode for the ASCII CAN
// line parser.
// ----------------------------------------------------------------------------
package acfp_pkg;

   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_EIGHT = 8'h38;
   localparam logic [7:0] CHAR_NINE  = 8'h39;
   localparam logic [7:0] CHAR_UP_A  = 8'h41;
   localparam logic [7:0] CHAR_UP_F  = 8'h46;
   localparam logic [7:0] CHAR_LO_A  = 8'h61;
   localparam logic [7:0] CHAR_LO_F  = 8'h66;
   localparam logic [7:0] CHAR_UP_R  = 8'h52;
   localparam logic [7:0] CHAR_UP_T  = 8'h54;
   localparam logic [7:0] CHAR_UP_Z  = 8'h5A;
   localparam logic [7:0] CHAR_LO_R  = 8'h72;
   localparam logic [7:0] CHAR_LO_T  = 8'h74;

   // line positions: length digit follows the identifier digits
   localparam logic [6:0] LEN_POS_STD = 7'd4;
   localparam logic [6:0] LEN_POS_EXT = 7'd9;
   localparam logic [6:0] MIN_LINE    = 7'd5;
   localparam logic [6:0] DATA_CHARS  = 7'd16;
   localparam logic [3:0] MAX_DLC     = 4'd8;

   typedef struct packed {
      logic        frame_ok;
      logic        is_extended;
      logic        is_remote;
      logic [31:0] frame_id;
      logic [3:0]  frame_len;
      logic [63:0] frame_data;
   } frame_type;

   // non-hex characters decode as zero
   function automatic logic [3:0] hex_value(input logic [7:0] c);
      logic [3:0] v;
      v = 4'd0;
      if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
         v = 4'(c - CHAR_ZERO);
      end else if (c >= CHAR_UP_A && c <= CHAR_UP_F) begin
         v = 4'(c - CHAR_UP_A + 8'd10);
      end else if (c >= CHAR_LO_A && c <= CHAR_LO_F) begin
         v = 4'(c - CHAR_LO_A + 8'd10);
      end
      return v;
   endfunction

endpackage

@@ rtl/acfp_line_state.sv @@
// ----------------------------------------------------------------------------
// acfp_line_state
// Per-line accumulators (position, lead byte, identifier, length, data) and
// the decode of the finished frame when a line ends.
// ----------------------------------------------------------------------------
module acfp_line_state
   import acfp_pkg::*;
#(
   parameter int MAX_LINE = 32
) (
   input  logic      clock,
   input  logic      reset,
   input  logic      step,
   input  logic [7:0] char_in,
   output logic      line_end,
   output frame_type frame
);

   localparam int POS_W = $clog2(MAX_LINE);

   logic [POS_W-1:0] pos_ff, pos_in;
   logic [7:0]       lead_ff, lead_in;
   logic             hdr_ff, hdr_in;
   logic [31:0]      id_ff, id_in;
   logic [3:0]       len_ff, len_in;
   logic [63:0]      data_ff, data_in;

   logic [6:0] pw, len_pos, base, chars, reached_raw;
   logic       term, ext, remote, ok, id_hit, data_hit;
   logic [2:0] digit_idx;
   logic [3:0] k, hex, reached, nbytes;
   logic [5:0] data_sh;
   logic [63:0] mask;

   always_comb begin
      pw      = 7'(pos_ff);
      term    = (char_in == CHAR_CR);
      hex     = hex_value(char_in);
      lead_in = (pw == 7'd0) ? char_in : lead_ff;
      ext     = (lead_in < CHAR_UP_Z);
      remote  = (lead_in == CHAR_LO_R) || (lead_in == CHAR_UP_R);
      len_pos = ext ? LEN_POS_EXT : LEN_POS_STD;
      base    = len_pos + 7'd1;

      if (pw == 7'd0) begin
         hdr_in = 1'b0;
      end else if (pw == 7'd1) begin
         hdr_in = ((lead_ff == CHAR_LO_T) || (lead_ff == CHAR_UP_T) ||
                   (lead_ff == CHAR_LO_R) || (lead_ff == CHAR_UP_R)) &&
                  (char_in >= CHAR_ZERO) && (char_in <= CHAR_NINE);
      end else begin
         hdr_in = hdr_ff;
      end

      // identifier: first digit most significant
      id_hit    = !term && (pw >= 7'd1) && (pw < len_pos);
      digit_idx = 3'(len_pos - 7'd1 - pw);
      id_in     = id_ff | (id_hit ? (32'(hex) << {digit_idx, 2'b00}) : 32'd0);

      if (pw == len_pos) begin
         len_in = (char_in >= CHAR_ZERO && char_in <= CHAR_EIGHT) ?
                  4'(char_in - CHAR_ZERO) : MAX_DLC;
      end else begin
         len_in = len_ff;
      end

      // data: high nibble first within each byte
      data_hit = !term && (pw >= base) && (pw < base + DATA_CHARS);
      k        = 4'(pw - base);
      data_sh  = {k[3:1], ~k[0], 2'b00};
      data_in  = data_ff | (data_hit ? (64'(hex) << data_sh) : 64'd0);

      line_end = term || (pw + 7'd1 >= 7'(MAX_LINE));
      pos_in   = POS_W'(pw + 7'd1);

      ok          = hdr_in && (pw + 7'd1 >= MIN_LINE);
      chars       = term ? pw : pw + 7'd1;
      reached_raw = (chars > base) ? ((chars - base) >> 1) : 7'd0;
      reached     = (reached_raw > 7'(MAX_DLC)) ? MAX_DLC : reached_raw[3:0];
      nbytes      = remote ? 4'd0 : ((len_in < reached) ? len_in : reached);
      for (int i = 0; i < 8; i++) begin
         mask[i*8 +: 8] = (4'(i) < nbytes) ? 8'hFF : 8'h00;
      end

      frame.frame_ok    = ok;
      frame.is_extended = ok && ext;
      frame.is_remote   = ok && remote;
      frame.frame_id    = ok ? id_in : 32'd0;
      frame.frame_len   = ok ? len_in : 4'd0;
      frame.frame_data  = ok ? (data_in & mask) : 64'd0;
   end

   always_ff @(posedge clock) begin
      if (reset || (step && line_end)) begin
         pos_ff  <= '0;
         lead_ff <= '0;
         hdr_ff  <= 1'b0;
         id_ff   <= '0;
         len_ff  <= '0;
         data_ff <= '0;
      end else if (step) begin
         pos_ff  <= pos_in;
         lead_ff <= lead_in;
         hdr_ff  <= hdr_in;
         id_ff   <= id_in;
         len_ff  <= len_in;
         data_ff <= data_in;
      end
   end

endmodule

@@ rtl/ascii_can_frame_parser.sv @@
// ----------------------------------------------------------------------------
// ascii_can_frame_parser
// Gathers slcan-style ASCII bytes into lines and gives one decoded CAN frame
// per line, at a carriage return or at the maximum line length.
// ----------------------------------------------------------------------------
// Throughput: one byte per cycle through input and result stages when unstalled.
// A closing byte is registered first, then its frame in the result register.
// The input stage only stalls when a frame is due and the result register
// still holds an untaken frame.
// Reset (synchronous) empties both stages and clears all line state.
module ascii_can_frame_parser
   import acfp_pkg::*;
#(
   parameter int MAX_LINE = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_char_in,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_frame_ok,
   output logic        rsp_is_extended,
   output logic        rsp_is_remote,
   output logic [31:0] rsp_frame_id,
   output logic [3:0]  rsp_frame_len,
   output logic [63:0] rsp_frame_data
);

   logic       in_valid_ff, in_valid_in;
   logic [7:0] char_ff;
   logic       rsp_valid_ff, rsp_valid_in;
   frame_type  frame_ff, frame;
   logic       line_end, out_free, fire, load;

   acfp_line_state #(
      .MAX_LINE (MAX_LINE)
   ) u_line (
      .clock    (clock),
      .reset    (reset),
      .step     (fire),
      .char_in  (char_ff),
      .line_end (line_end),
      .frame    (frame)
   );

   // a byte that closes a line needs room in the result register
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign fire      = in_valid_ff && (!line_end || out_free);
   assign load      = fire && line_end;
   assign req_ready = !in_valid_ff || fire;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_valid && req_ready) begin
         in_valid_in = 1'b1;
      end else if (fire) begin
         in_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         char_ff <= req_char_in;
      end
      if (load) begin
         frame_ff <= frame;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_frame_ok    = frame_ff.frame_ok;
   assign rsp_is_extended = frame_ff.is_extended;
   assign rsp_is_remote   = frame_ff.is_remote;
   assign rsp_frame_id    = frame_ff.frame_id;
   assign rsp_frame_len   = frame_ff.frame_len;
   assign rsp_frame_data  = frame_ff.frame_data;

   // malformed lines carry nothing but the flag
   a_bad_line_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_frame_ok |->
         rsp_frame_id == 32'd0 && rsp_frame_data == 64'd0 &&
         rsp_frame_len == 4'd0 && !rsp_is_extended && !rsp_is_remote)
      else $error("malformed line reported with non-zero fields");

   a_len_clamped: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_frame_len <= MAX_DLC)
      else $error("frame length above eight");

   a_remote_no_data: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_is_remote |-> rsp_frame_data == 64'd0)
      else $error("remote frame carries data");

   // a held byte must not be overwritten while it waits
   a_input_held: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !fire |=> in_valid_ff && $stable(char_ff))
      else $error("stalled input byte lost");

endmodule
